// ===== rtl/core/adc_oversample_vref_calibrate_unit_assert.svh =====
// Assertion helpers used by the checker file.
`ifndef ADC_OVERSAMPLE_VREF_CALIBRATE_UNIT_ASSERT_SVH
`define ADC_OVERSAMPLE_VREF_CALIBRATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define AOVC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("aovc: property failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define AOVC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("aovc: property failed");

`endif

// ===== rtl/core/aovc_pkg.sv =====
`timescale 1ns / 1ps
package aovc_pkg;

    // Block geometry
    localparam int SAMPLES_PER_CHANNEL = 10;
    localparam int NUM_CHANNELS        = 3;
    localparam int SAMPLE_W            = 12;
    localparam int SUM_W               = 18;
    localparam int ROUND_W             = 6;
    localparam int CH_W                = 2;
    localparam int MV_W                = 16;
    localparam int FULL_SCALE          = 4095;

    // Shared divider: 28-bit dividend, 12-bit divisor, one quotient bit a cycle
    localparam int DIVIDEND_W = 28;
    localparam int DIVISOR_W  = 12;
    localparam int DIV_CNT_W  = 5;
    localparam int VREF_PROD_W = 24;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_VREF = 1'b0;
    localparam logic [SAMPLE_W-1:0] VREF_RESET = 12'd1217;

    // Stream payload layout
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;
    localparam int AVG_LSB   = 0;
    localparam int MV_LSB    = 12;
    localparam int SUP_LSB   = 28;
    localparam int SAT_BIT   = 44;

    // Channel codes
    localparam logic [CH_W-1:0] CH_SOLAR = 2'd0;
    localparam logic [CH_W-1:0] CH_SCAP  = 2'd1;
    localparam logic [CH_W-1:0] CH_REF   = 2'd2;

    // Microprogram
    localparam int PC_W        = 5;
    localparam int UCODE_DEPTH = 26;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD_SUM,
        OP_STORE_AVG,
        OP_LOAD_VREF,
        OP_STORE_SUPPLY,
        OP_MUL,
        OP_LOAD_PROD,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } ucond_t;

    typedef struct packed {
        uop_t              op;
        logic [CH_W-1:0]   ch;
        ucond_t            cond;
        logic [PC_W-1:0]   target;
    } uword_t;

    function automatic uword_t uw(uop_t op, logic [CH_W-1:0] ch, ucond_t cond,
                                  logic [PC_W-1:0] target);
        uword_t w;
        w.op     = op;
        w.ch     = ch;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store: averages, supply quotient, then per-channel scale and emit
    function automatic uword_t ucode_rom(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:  w = uw(OP_NOP,          CH_SOLAR, COND_NO_START, 5'd0);
            5'd1:  w = uw(OP_LOAD_SUM,     CH_SOLAR, COND_NEVER,    5'd0);
            5'd2:  w = uw(OP_NOP,          CH_SOLAR, COND_DIV_BUSY, 5'd2);
            5'd3:  w = uw(OP_STORE_AVG,    CH_SOLAR, COND_NEVER,    5'd0);
            5'd4:  w = uw(OP_LOAD_SUM,     CH_SCAP,  COND_NEVER,    5'd0);
            5'd5:  w = uw(OP_NOP,          CH_SCAP,  COND_DIV_BUSY, 5'd5);
            5'd6:  w = uw(OP_STORE_AVG,    CH_SCAP,  COND_NEVER,    5'd0);
            5'd7:  w = uw(OP_LOAD_SUM,     CH_REF,   COND_NEVER,    5'd0);
            5'd8:  w = uw(OP_NOP,          CH_REF,   COND_DIV_BUSY, 5'd8);
            5'd9:  w = uw(OP_STORE_AVG,    CH_REF,   COND_NEVER,    5'd0);
            5'd10: w = uw(OP_LOAD_VREF,    CH_REF,   COND_NEVER,    5'd0);
            5'd11: w = uw(OP_NOP,          CH_REF,   COND_DIV_BUSY, 5'd11);
            5'd12: w = uw(OP_STORE_SUPPLY, CH_REF,   COND_NEVER,    5'd0);
            5'd13: w = uw(OP_MUL,          CH_SOLAR, COND_NEVER,    5'd0);
            5'd14: w = uw(OP_LOAD_PROD,    CH_SOLAR, COND_NEVER,    5'd0);
            5'd15: w = uw(OP_NOP,          CH_SOLAR, COND_DIV_BUSY, 5'd15);
            5'd16: w = uw(OP_EMIT,         CH_SOLAR, COND_OUT_BUSY, 5'd16);
            5'd17: w = uw(OP_MUL,          CH_SCAP,  COND_NEVER,    5'd0);
            5'd18: w = uw(OP_LOAD_PROD,    CH_SCAP,  COND_NEVER,    5'd0);
            5'd19: w = uw(OP_NOP,          CH_SCAP,  COND_DIV_BUSY, 5'd19);
            5'd20: w = uw(OP_EMIT,         CH_SCAP,  COND_OUT_BUSY, 5'd20);
            5'd21: w = uw(OP_MUL,          CH_REF,   COND_NEVER,    5'd0);
            5'd22: w = uw(OP_LOAD_PROD,    CH_REF,   COND_NEVER,    5'd0);
            5'd23: w = uw(OP_NOP,          CH_REF,   COND_DIV_BUSY, 5'd23);
            5'd24: w = uw(OP_EMIT,         CH_REF,   COND_OUT_BUSY, 5'd24);
            5'd25: w = uw(OP_NOP,          CH_SOLAR, COND_ALWAYS,   5'd0);
            default: w = uw(OP_NOP,        CH_SOLAR, COND_ALWAYS,   5'd0);
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/adc_oversample_vref_calibrate_unit.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake                  | Payload
// s_       | in        | s_tvalid / s_tready        | s_tdata: sample
// m_       | out       | m_tvalid / m_tready        | m_tdata, m_tuser (channel), m_tlast
// APB      | in        | psel & penable, pready = 1 | vref_expected_mv at address 0
//
// A sample that does not close a block is taken at once; s_tready stays high.
// The sample that closes a block starts the microprogram: seven passes of
// the shared shift-subtract divider plus the load, store, multiply and emit steps;
// the next sample is taken only when it ends, later while m_tready holds off any of the three beats.
// The last beat of a block may wait in the output register while sampling resumes.
// aresetn is synchronous, active low; it clears the counters, sums, sequencer,
// divider and output valid, and restores vref_expected_mv to 1217.
module adc_oversample_vref_calibrate_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [aovc_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [aovc_pkg::M_TDATA_W-1:0]    m_tdata,   // [11:0] raw_average,
                                                         // [27:12] millivolts,
                                                         // [43:28] supply_mv,
                                                         // [44] supply_saturated
    output logic [aovc_pkg::CH_W-1:0]         m_tuser,   // [1:0] channel
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [aovc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [aovc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [aovc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import aovc_pkg::*;

    logic [SAMPLE_W-1:0]   vref_reg;
    logic [CH_W-1:0]       slot_reg;
    logic [ROUND_W-1:0]    round_reg;
    logic [SUM_W-1:0]      sum_reg [NUM_CHANNELS];
    logic [SAMPLE_W-1:0]   avg_reg [NUM_CHANNELS];
    logic [MV_W-1:0]       supply_reg;
    logic                  sat_reg;
    logic [DIVIDEND_W-1:0] prod_reg;

    logic [PC_W-1:0]       pc_reg, pc_next;
    uword_t                uword;
    logic                  jump;

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  trial_ok;
    logic                  div_busy;

    logic                  out_valid_reg;
    logic [CH_W-1:0]       out_ch_reg;
    logic [SAMPLE_W-1:0]   out_avg_reg;
    logic [MV_W-1:0]       out_mv_reg;
    logic [MV_W-1:0]       out_sup_reg;
    logic                  out_sat_reg;
    logic                  out_last_reg;
    logic                  out_busy;

    logic                  s_beat;
    logic                  block_end;
    logic                  cfg_write;
    logic [VREF_PROD_W-1:0] vref_prod;

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_VREF) ? APB_DATA_W'(vref_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg <= VREF_RESET;
        end else if (cfg_write && paddr[APB_ADDR_W-1:2] == REG_VREF) begin
            vref_reg <= pwdata[SAMPLE_W-1:0];
        end
    end

    // Input side: only the idle step takes samples
    assign s_tready  = (pc_reg == '0);
    assign s_beat    = s_tvalid & s_tready;
    assign block_end = s_beat && slot_reg == CH_REF &&
                       round_reg == ROUND_W'(SAMPLES_PER_CHANNEL - 1);

    // Scan position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg  <= CH_SOLAR;
            round_reg <= '0;
        end else if (s_beat) begin
            if (slot_reg == CH_REF) begin
                slot_reg <= CH_SOLAR;
                if (block_end) begin
                    round_reg <= '0;
                end else begin
                    round_reg <= round_reg + 1'b1;
                end
            end else begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    // Per-channel sums, cleared as each one is handed to the divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                sum_reg[c] <= '0;
            end
        end else if (s_beat) begin
            sum_reg[slot_reg] <= sum_reg[slot_reg] + SUM_W'(s_tdata[SAMPLE_W-1:0]);
        end else if (uword.op == OP_LOAD_SUM) begin
            sum_reg[uword.ch] <= '0;
        end
    end

    // Sequencer: fetch, evaluate jump condition
    assign uword    = ucode_rom(pc_reg);
    assign div_busy = (cnt_reg != '0);
    assign out_busy = out_valid_reg & ~m_tready;

    always_comb begin
        case (uword.cond)
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_START: jump = ~block_end;
            COND_DIV_BUSY: jump = div_busy;
            COND_OUT_BUSY: jump = out_busy;
            default:       jump = 1'b0;
        endcase
        pc_next = jump ? uword.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
        end else begin
            pc_reg <= pc_next;
        end
    end

    // Shared restoring divider, one quotient bit a cycle
    assign vref_prod = {vref_reg, 12'b0} - VREF_PROD_W'(vref_reg);
    assign trial     = {rem_reg, quo_reg[DIVIDEND_W-1]} - {1'b0, dvs_reg};
    assign trial_ok  = ({rem_reg, quo_reg[DIVIDEND_W-1]} >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (uword.op == OP_LOAD_SUM || uword.op == OP_LOAD_VREF ||
                     uword.op == OP_LOAD_PROD) begin
            cnt_reg <= DIV_CNT_W'(DIVIDEND_W);
        end else if (div_busy) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (uword.op)
            OP_LOAD_SUM: begin
                quo_reg <= DIVIDEND_W'(sum_reg[uword.ch]);
                dvs_reg <= DIVISOR_W'(SAMPLES_PER_CHANNEL);
                rem_reg <= '0;
            end
            OP_LOAD_VREF: begin
                quo_reg <= DIVIDEND_W'(vref_prod);
                dvs_reg <= avg_reg[CH_REF];
                rem_reg <= '0;
            end
            OP_LOAD_PROD: begin
                quo_reg <= prod_reg;
                dvs_reg <= DIVISOR_W'(FULL_SCALE);
                rem_reg <= '0;
            end
            default: begin
                if (div_busy) begin
                    quo_reg <= {quo_reg[DIVIDEND_W-2:0], trial_ok};
                    rem_reg <= trial_ok ? trial[DIVISOR_W-1:0]
                                        : {rem_reg[DIVISOR_W-2:0], quo_reg[DIVIDEND_W-1]};
                end
            end
        endcase
    end

    // Datapath registers written by the microprogram
    always_ff @(posedge aclk) begin
        case (uword.op)
            OP_STORE_AVG: begin
                avg_reg[uword.ch] <= quo_reg[SAMPLE_W-1:0];
            end
            OP_STORE_SUPPLY: begin
                // zero divisor gives an all-ones quotient, so it saturates too
                sat_reg    <= (quo_reg[DIVIDEND_W-1:MV_W] != '0);
                supply_reg <= (quo_reg[DIVIDEND_W-1:MV_W] != '0) ? '1 : quo_reg[MV_W-1:0];
            end
            OP_MUL: begin
                prod_reg <= DIVIDEND_W'(avg_reg[uword.ch]) * DIVIDEND_W'(supply_reg);
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (uword.op == OP_EMIT && !out_busy) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (uword.op == OP_EMIT && !out_busy) begin
            out_ch_reg   <= uword.ch;
            out_avg_reg  <= avg_reg[uword.ch];
            out_mv_reg   <= quo_reg[MV_W-1:0];
            out_sup_reg  <= supply_reg;
            out_sat_reg  <= sat_reg;
            out_last_reg <= (uword.ch == CH_REF);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b0, out_sat_reg, out_sup_reg, out_mv_reg, out_avg_reg};
    assign m_tuser  = out_ch_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== rtl/core/aovc_checker.sv =====
`timescale 1ns / 1ps
`include "adc_oversample_vref_calibrate_unit_assert.svh"
module aovc_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [aovc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [aovc_pkg::CH_W-1:0]       m_tuser,
    input  logic                            m_tlast
);
    import aovc_pkg::*;

    // a stalled beat holds its payload
    `AOVC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // last beat of a run is the reference channel, and only that one
    `AOVC_ASSERT_SAME(a_last_ref, aclk, aresetn, m_tvalid, m_tlast == (m_tuser == CH_REF))

    // saturated supply reads full scale
    `AOVC_ASSERT_SAME(a_sat_full, aclk, aresetn, m_tvalid && m_tdata[SAT_BIT], m_tdata[SUP_LSB+MV_W-1:SUP_LSB] == 16'hFFFF)

    // scaled channel never exceeds the supply
    `AOVC_ASSERT_SAME(a_mv_le_sup, aclk, aresetn, m_tvalid, m_tdata[MV_LSB+MV_W-1:MV_LSB] <= m_tdata[SUP_LSB+MV_W-1:SUP_LSB])

endmodule

bind adc_oversample_vref_calibrate_unit aovc_checker u_aovc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import aovc_pkg::*;

    localparam int CLK_HALF_NS   = 2;
    localparam int RESET_CYCLES  = 5;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 40;     // microprogram tail after the last beat
    localparam int TAIL_CYCLES   = 300;    // more than one full end-of-block pass
    localparam int HOLD_CYCLES   = 900;    // long receiver hold-off
    localparam int RUN_LIMIT_NS  = 2_000_000;
    localparam int SCAN_LEN      = SAMPLES_PER_CHANNEL * NUM_CHANNELS;

    localparam logic [APB_ADDR_W-1:0] VREF_ADDR  = {REG_VREF, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = 3'd4;   // byte address of the word past the register list

    // One output beat as the block should present it
    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] raw_average;
        logic [MV_W-1:0]     millivolts;
        logic [MV_W-1:0]     supply_mv;
        logic                saturated;
        logic                last;
    } reading_t;

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata  = '0;   // [11:0] sample
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_W-1:0]    m_tdata;         // [11:0] raw_average, [27:12] millivolts,
                                              // [43:28] supply_mv, [44] supply_saturated
    logic [CH_W-1:0]         m_tuser;         // [1:0] channel
    logic                    m_tlast;
    logic                    psel     = 1'b0;
    logic                    penable  = 1'b0;
    logic                    pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr    = '0;
    logic [APB_DATA_W-1:0]   pwdata   = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    // Shadow of the block's state
    logic [SAMPLE_W-1:0]     vref_mv_shadow = VREF_RESET;
    logic [CH_W-1:0]         scan_slot_shadow = '0;
    logic [ROUND_W-1:0]      round_shadow = '0;
    logic [SUM_W-1:0]        sum_shadow [NUM_CHANNELS] = '{default: '0};

    logic [SAMPLE_W-1:0]     sample_queue [$];
    reading_t                expected_readings [$];

    logic s_taken = 1'b0;
    logic m_taken = 1'b0;
    logic tx_gapless = 1'b0;
    logic rx_gapless = 1'b0;
    int   tx_wait = 0;
    int   rx_wait = 0;
    int   rx_hold_left = 0;

    int mismatches = 0;
    int samples_taken = 0;
    int readings_checked = 0;
    int saturated_blocks = 0;
    int vref_settings = 0;

    adc_oversample_vref_calibrate_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #(CLK_HALF_NS) aclk = ~aclk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d readings still outstanding", expected_readings.size());
        $display("adc_oversample_vref_calibrate_unit: mismatch");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Accumulate one sample; at block end compute averages, supply and per-channel mV
    task automatic fold_sample(input logic [SAMPLE_W-1:0] sample);
        logic [SAMPLE_W-1:0] avg [NUM_CHANNELS];
        logic [MV_W-1:0]     supply;
        logic                sat;
        int unsigned         quotient;
        int unsigned         scaled;
        int                  ch;
        reading_t            r;
        ch = (scan_slot_shadow >= NUM_CHANNELS) ? 0 : int'(scan_slot_shadow);
        sum_shadow[ch] = sum_shadow[ch] + SUM_W'(sample);
        if (ch + 1 < NUM_CHANNELS) begin
            scan_slot_shadow = CH_W'(ch + 1);
            return;
        end
        scan_slot_shadow = '0;
        if (int'(round_shadow) + 1 < SAMPLES_PER_CHANNEL) begin
            round_shadow = round_shadow + 1'b1;
            return;
        end
        round_shadow = '0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            avg[c] = SAMPLE_W'(sum_shadow[c] / SAMPLES_PER_CHANNEL);
            sum_shadow[c] = '0;
        end
        // Zero reference or oversized quotient pins the supply at full 16 bits
        sat = 1'b0;
        if (avg[CH_REF] == '0) begin
            supply = '1;
            sat = 1'b1;
        end else begin
            quotient = (32'(vref_mv_shadow) * 32'(FULL_SCALE)) / 32'(avg[CH_REF]);
            if (quotient > 32'hFFFF) begin
                supply = '1;
                sat = 1'b1;
            end else begin
                supply = MV_W'(quotient);
            end
        end
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            scaled = (32'(avg[c]) * 32'(supply)) / 32'(FULL_SCALE);
            r.channel     = CH_W'(c);
            r.raw_average = avg[c];
            r.millivolts  = (scaled > 32'hFFFF) ? '1 : MV_W'(scaled);
            r.supply_mv   = supply;
            r.saturated   = sat;
            r.last        = (r.channel == CH_REF);
            expected_readings.push_back(r);
        end
    endtask

    // Input and output monitors; the predictor runs on every accepted sample
    always @(posedge aclk) begin
        reading_t want;
        s_taken <= aresetn && s_tvalid && s_tready;
        m_taken <= aresetn && m_tvalid && m_tready;
        if (aresetn && s_tvalid && s_tready) begin
            fold_sample(s_tdata[SAMPLE_W-1:0]);
            samples_taken++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("beat with nothing expected, tdata", m_tdata, 0);
            end else begin
                want = expected_readings.pop_front();
                if (m_tuser !== want.channel)
                    report_mismatch("channel", m_tuser, want.channel);
                if (m_tdata[AVG_LSB +: SAMPLE_W] !== want.raw_average)
                    report_mismatch("raw_average", m_tdata[AVG_LSB +: SAMPLE_W],
                                    want.raw_average);
                if (m_tdata[MV_LSB +: MV_W] !== want.millivolts)
                    report_mismatch("millivolts", m_tdata[MV_LSB +: MV_W], want.millivolts);
                if (m_tdata[SUP_LSB +: MV_W] !== want.supply_mv)
                    report_mismatch("supply_mv", m_tdata[SUP_LSB +: MV_W], want.supply_mv);
                if (m_tdata[SAT_BIT] !== want.saturated)
                    report_mismatch("supply_saturated", m_tdata[SAT_BIT], want.saturated);
                if (m_tlast !== want.last)
                    report_mismatch("tlast", m_tlast, want.last);
                readings_checked++;
                if (want.last && want.saturated)
                    saturated_blocks++;
            end
        end
    end

    // Sample driver: random gap after each beat unless running gapless
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            tx_wait = 0;
        end else if (!s_tvalid || s_taken) begin
            if (tx_wait > 0) begin
                tx_wait = tx_wait - 1;
                s_tvalid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                s_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, sample_queue.pop_front()};
                s_tvalid <= 1'b1;
                tx_wait = tx_gapless ? 0 : $urandom_range(MAX_GAP, 0);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall after each beat, plus an optional long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait = 0;
        end else if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
        end else begin
            if (m_taken)
                rx_wait = rx_gapless ? 0 : $urandom_range(MAX_GAP, 0);
            else if (rx_wait > 0)
                rx_wait = rx_wait - 1;
            m_tready <= (rx_wait == 0);
        end
    end

    // Hold-off countdown
    always @(posedge aclk) begin
        if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Two-phase APB access; a read is checked against the shadow register
    task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (write && addr == VREF_ADDR) begin
            vref_mv_shadow = data[SAMPLE_W-1:0];
            vref_settings++;
        end else if (!write && prdata !== APB_DATA_W'(vref_mv_shadow)) begin
            report_mismatch("vref_expected_mv readback", prdata, vref_mv_shadow);
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One block of full scans; reference and other channels drawn from their own ranges
    task automatic queue_block(input int ref_lo, input int ref_hi,
                               input int other_lo, input int other_hi);
        for (int i = 0; i < SCAN_LEN; i++) begin
            if (i % NUM_CHANNELS == int'(CH_REF))
                sample_queue.push_back(SAMPLE_W'($urandom_range(ref_hi, ref_lo)));
            else
                sample_queue.push_back(SAMPLE_W'($urandom_range(other_hi, other_lo)));
        end
    endtask

    // Wait until all samples are in and all readings are out, then let the block settle
    task automatic drain();
        while (sample_queue.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int center;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset calibration value: full-scale block, all-zero block, and a block whose
        // reference samples lie between 0 and 9
        apb_access(1'b0, VREF_ADDR, '0);
        tx_gapless = 1'b1;
        rx_gapless = 1'b1;
        queue_block(4095, 4095, 4095, 4095);
        queue_block(0, 0, 0, 0);
        queue_block(0, 9, 0, 4095);
        drain();

        // Maximum register value through dropped upper bits; spare address ignored
        apb_access(1'b1, VREF_ADDR, 32'hFFFF_FFFF);
        apb_access(1'b1, SPARE_ADDR, $urandom);
        apb_access(1'b0, VREF_ADDR, '0);
        tx_gapless = 1'b0;
        rx_gapless = 1'b0;
        queue_block(1, 1, 0, 4095);        // quotient overflow
        queue_block(200, 300, 0, 4095);    // near the overflow boundary
        queue_block(4095, 4095, 0, 4095);
        drain();

        // Zero calibration: supply collapses to zero unless the reference is zero
        apb_access(1'b1, VREF_ADDR, 32'hFFFF_F000);
        apb_access(1'b0, VREF_ADDR, '0);
        queue_block(0, 4095, 0, 4095);
        queue_block(0, 0, 0, 4095);
        drain();

        // Top of the nominal range with the receiver held off so the block backs up
        apb_access(1'b1, VREF_ADDR, 32'd3300);
        tx_gapless = 1'b1;
        @(negedge aclk);
        rx_hold_left = HOLD_CYCLES;
        queue_block(1000, 2000, 0, 4095);
        queue_block(1000, 2000, 0, 4095);
        drain();

        // Random setting and block content
        apb_access(1'b1, VREF_ADDR,
                   ($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(1800, 900));
        tx_gapless = ($urandom_range(3, 0) == 0);
        rx_gapless = ($urandom_range(3, 0) == 0);
        case ($urandom_range(3, 0))
            0: queue_block(0, 80, 0, 4095);
            1: queue_block(0, 4095, 0, 4095);
            default: begin
                center = $urandom_range(2600, 800);
                queue_block(center - 150, center + 150,
                            $urandom_range(2047, 0), $urandom_range(4095, 2048));
            end
        endcase
        drain();

        // Partial block: must produce nothing
        tx_gapless = 1'b0;
        for (int i = 0; i < 7; i++)
            sample_queue.push_back(SAMPLE_W'($urandom));
        while (sample_queue.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d samples and %0d checked readings under %0d calibration writes;",
                 samples_taken, readings_checked, vref_settings);
        $display("%0d blocks ended with a saturated supply, %0d mismatches",
                 saturated_blocks, mismatches);
        if (mismatches == 0) begin
            $display("adc_oversample_vref_calibrate_unit: match");
        end else begin
            $display("adc_oversample_vref_calibrate_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== adc_oversample_vref_calibrate_unit.f =====
+incdir+rtl/core
rtl/core/aovc_pkg.sv
rtl/core/adc_oversample_vref_calibrate_unit.sv
rtl/core/aovc_checker.sv
verif/testbench.sv
